@@ src/ktt_pkg.sv @@
// ----------------------------------------------------------------------------
// ktt_pkg: shared types and constants of the keyed timeout table
// Table depth, field widths, op and status codes, cell command and
// result structures, controller states.
// ----------------------------------------------------------------------------
package ktt_pkg;

   localparam int TABLE_DEPTH = 16;

   localparam int KEY_W     = 32;
   localparam int IDENT_W   = 32;
   localparam int STAMP_W   = 64;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 3;
   localparam int REQ_DATA_W = 320;
   localparam int RSP_DATA_W = 192;

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER   = 2'd0,
      OP_UNREGISTER = 2'd1,
      OP_CHECK      = 2'd2
   } ktt_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_STORED      = 3'd0,
      STAT_OVERWRITTEN = 3'd1,
      STAT_DROPPED     = 3'd2,
      STAT_REMOVED     = 3'd3,
      STAT_NOT_FOUND   = 3'd4,
      STAT_EXPIRED     = 3'd5,
      STAT_DONE        = 3'd6,
      STAT_SKIPPED     = 3'd7
   } ktt_status_type;

   typedef enum logic [2:0] {
      CMD_IDLE,
      CMD_INSERT,
      CMD_REMOVE,
      CMD_EVAL,
      CMD_POP
   } ktt_cmd_kind_type;

   typedef struct packed {
      ktt_cmd_kind_type         kind;
      logic [KEY_W-1:0]         key;
      logic [IDENT_W-1:0]       ident;
      logic [STAMP_W-1:0]       tag;
      logic [STAMP_W-1:0]       start;
      logic [STAMP_W-1:0]       dur;
      logic [STAMP_W-1:0]       now;
   } ktt_cmd_type;

   typedef struct packed {
      logic [STAMP_W-1:0]       elapsed;
      logic [STAMP_W-1:0]       tag;
      logic [IDENT_W-1:0]       ident;
      logic [KEY_W-1:0]         key;
   } ktt_emit_type;

   typedef struct packed {
      logic hit;
      logic sel;
   } ktt_cell_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } ktt_state_type;

endpackage

@@ src/ktt_cell.sv @@
// ----------------------------------------------------------------------------
// ktt_cell: one slot of the timeout table
// Holds one entry, compares its key, claims itself on insert through the
// free chain, flags expiry on evaluate and drives its entry on pop through
// the pending chain.
// ----------------------------------------------------------------------------
module ktt_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  ktt_pkg::ktt_cmd_type       cmd,
   input  logic                       hit_any,
   input  logic                       free_in,
   output logic                       free_out,
   input  logic                       pend_in,
   output logic                       pend_out,
   output ktt_pkg::ktt_cell_stat_type stat,
   output ktt_pkg::ktt_emit_type      emit
);
   import ktt_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 exp_ff, exp_in;
   logic [KEY_W-1:0]     key_ff;
   logic [IDENT_W-1:0]   ident_ff;
   logic [STAMP_W-1:0]   tag_ff;
   logic [STAMP_W-1:0]   start_ff;
   logic [STAMP_W-1:0]   dur_ff;
   logic [STAMP_W-1:0]   elapsed_ff, elapsed_in;
   logic                 hit, claim, write, sel;

   assign hit      = valid_ff && (key_ff == cmd.key);
   assign claim    = !hit_any && !valid_ff && !free_in;
   assign free_out = free_in || !valid_ff;
   assign sel      = exp_ff && !pend_in;
   assign pend_out = pend_in || exp_ff;
   assign write    = (cmd.kind == CMD_INSERT) && (hit || claim);

   assign elapsed_in = cmd.now - start_ff;

   always_comb begin
      valid_in = valid_ff;
      exp_in   = exp_ff;
      unique case (cmd.kind)
         CMD_INSERT: begin
            if (write) valid_in = 1'b1;
         end
         CMD_REMOVE: begin
            if (hit) valid_in = 1'b0;
         end
         CMD_EVAL: begin
            exp_in = valid_ff && ($signed(elapsed_in) >= $signed(dur_ff));
         end
         CMD_POP: begin
            if (sel) begin
               valid_in = 1'b0;
               exp_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         exp_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         exp_ff   <= exp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write) begin
         key_ff   <= cmd.key;
         ident_ff <= cmd.ident;
         tag_ff   <= cmd.tag;
         start_ff <= cmd.start;
         dur_ff   <= cmd.dur;
      end
      if (cmd.kind == CMD_EVAL) begin
         elapsed_ff <= elapsed_in;
      end
   end

   assign stat.hit = hit;
   assign stat.sel = sel;

   assign emit.key     = sel ? key_ff     : '0;
   assign emit.ident   = sel ? ident_ff   : '0;
   assign emit.tag     = sel ? tag_ff     : '0;
   assign emit.elapsed = sel ? elapsed_ff : '0;

endmodule

@@ src/keyed_timeout_table_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_timeout_table_unit: table of pending timeouts, one entry per key
// Row of table cells under a small controller with a registered result.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per beat: register, unregister or check.
//   rsp_* returns result beats; rsp_tlast marks the last beat of an item.
//   csr_* writes the check interval; write it only while the block is idle.
// Sequence:
//   Register and unregister: the beat is captured, then the parallel key
//   compare and write in all cells runs and the result beat is loaded.
//   A skipped check loads its skipped beat after capture. A check that runs
//   does an evaluate step in all cells, then loads one beat per expired
//   entry through the pending chain in slot order, then the done beat.
//   The next item is taken once the previous one has placed its last beat
//   in the output register, while that beat may still wait.
// Reset:
//   Clears all valid and expiry flags, the last check time and the result
//   valid flag, and loads the check interval with 1000. Ready right after.
// Stall:
//   A low rsp_tready stalls each result load until the register frees.
// ----------------------------------------------------------------------------
module keyed_timeout_table_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entity_key, action_ident, action_tag, start_stamp, duration, now_stamp
   input  logic [ktt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op
   input  logic [ktt_pkg::OP_W-1:0]        req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_key, out_action_ident, out_action_tag, elapsed
   output logic [ktt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status
   output logic [ktt_pkg::STATUS_W-1:0]    rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [31:0]                     csr_data
);
   import ktt_pkg::*;

   ktt_state_type        state_ff, state_in;
   logic [31:0]          interval_ff;
   logic [STAMP_W-1:0]   last_check_ff, last_check_in;

   logic [OP_W-1:0]      op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [IDENT_W-1:0]   ident_ff;
   logic [STAMP_W-1:0]   tag_ff, start_ff, dur_ff, now_ff;

   logic                 out_valid_ff, out_valid_in;
   ktt_status_type       out_status_ff;
   ktt_emit_type         out_data_ff;
   logic                 out_last_ff;

   logic                 out_load, out_free;
   ktt_status_type       load_status;
   ktt_emit_type         load_data;
   logic                 load_last;

   ktt_cmd_type          cmd;
   ktt_cmd_kind_type     cmd_kind;
   logic [TABLE_DEPTH:0] free_chain, pend_chain;
   ktt_cell_stat_type    cell_stat [TABLE_DEPTH];
   ktt_emit_type         cell_emit [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] hit_vec, sel_vec;
   logic                 hit_any, pend_any, free_any;
   ktt_emit_type         emit_or;
   logic [STAMP_W-1:0]   diff;
   logic                 skip;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= 32'd1000;
      end else if (csr_valid && csr_ready) begin
         interval_ff <= csr_data;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff    <= req_tuser;
         key_ff   <= req_tdata[31:0];
         ident_ff <= req_tdata[63:32];
         tag_ff   <= req_tdata[127:64];
         start_ff <= req_tdata[191:128];
         dur_ff   <= req_tdata[255:192];
         now_ff   <= req_tdata[319:256];
      end
   end

   assign cmd.kind  = cmd_kind;
   assign cmd.key   = key_ff;
   assign cmd.ident = ident_ff;
   assign cmd.tag   = tag_ff;
   assign cmd.start = start_ff;
   assign cmd.dur   = dur_ff;
   assign cmd.now   = now_ff;

   assign free_chain[0] = 1'b0;
   assign pend_chain[0] = 1'b0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ktt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .hit_any  (hit_any),
         .free_in  (free_chain[i]),
         .free_out (free_chain[i+1]),
         .pend_in  (pend_chain[i]),
         .pend_out (pend_chain[i+1]),
         .stat     (cell_stat[i]),
         .emit     (cell_emit[i])
      );
      assign hit_vec[i] = cell_stat[i].hit;
      assign sel_vec[i] = cell_stat[i].sel;
   end

   assign hit_any  = |hit_vec;
   assign free_any = free_chain[TABLE_DEPTH];
   assign pend_any = pend_chain[TABLE_DEPTH];

   always_comb begin
      emit_or = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         emit_or = emit_or | cell_emit[i];
      end
   end

   assign diff = now_ff - last_check_ff;
   assign skip = diff[STAMP_W-1] || (diff < {32'd0, interval_ff});
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      last_check_in = last_check_ff;
      cmd_kind      = CMD_IDLE;
      out_load      = 1'b0;
      load_status   = STAT_DONE;
      load_data     = '0;
      load_data.key = key_ff;
      load_last     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_ff)
               OP_REGISTER: begin
                  if (out_free) begin
                     cmd_kind    = CMD_INSERT;
                     out_load    = 1'b1;
                     load_status = hit_any ? STAT_OVERWRITTEN :
                                   free_any ? STAT_STORED : STAT_DROPPED;
                     state_in    = ST_IDLE;
                  end
               end
               OP_UNREGISTER: begin
                  if (out_free) begin
                     cmd_kind    = CMD_REMOVE;
                     out_load    = 1'b1;
                     load_status = hit_any ? STAT_REMOVED : STAT_NOT_FOUND;
                     state_in    = ST_IDLE;
                  end
               end
               OP_CHECK: begin
                  if (!skip) begin
                     cmd_kind      = CMD_EVAL;
                     last_check_in = now_ff;
                     state_in      = ST_SCAN;
                  end else if (out_free) begin
                     out_load    = 1'b1;
                     load_status = STAT_SKIPPED;
                     state_in    = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            if (out_free) begin
               out_load = 1'b1;
               if (pend_any) begin
                  cmd_kind    = CMD_POP;
                  load_status = STAT_EXPIRED;
                  load_data   = emit_or;
                  load_last   = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_check_ff <= '0;
      end else begin
         state_ff      <= state_in;
         last_check_ff <= last_check_in;
      end
   end

   assign out_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_status_ff <= load_status;
         out_data_ff   <= load_data;
         out_last_ff   <= load_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef NO_ASSERTIONS
   a_one_sel: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel_vec))
      else $error("more than one cell drives the result");

   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("key held by more than one cell");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_any)
      else $error("expired entries left after check done");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result register overwritten before taken");
`endif

endmodule

@@ verif/keyed_timeout_table_checker.sv @@
// ----------------------------------------------------------------------------
// keyed_timeout_table_checker: result checker for the keyed timeout table
// Watches the request, result and interval-write channels. Each accepted
// request beat is run through a local copy of the table to build the
// expected result beats. Each accepted result beat is then compared field by
// field with the oldest expected beat.
// ----------------------------------------------------------------------------
module keyed_timeout_table_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // entity_key, action_ident, action_tag, start_stamp, duration, now_stamp
   input  logic [ktt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op
   input  logic [ktt_pkg::OP_W-1:0]        req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_key, out_action_ident, out_action_tag, elapsed
   input  logic [ktt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status
   input  logic [ktt_pkg::STATUS_W-1:0]    rsp_tuser,
   input  logic                            rsp_tlast,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [31:0]                     csr_data,
   output int                              mismatch_count,
   output int                              pending_beats,
   output int                              request_beats,
   output int                              result_beats,
   output int                              expired_beats
);
   import ktt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      ktt_status_type       status;
      logic [KEY_W-1:0]     key;
      logic [IDENT_W-1:0]   ident;
      logic [STAMP_W-1:0]   tag;
      logic [STAMP_W-1:0]   elapsed;
      logic                 last;
   } timeout_beat_type;

   timeout_beat_type       expected_beats_q[$];
   logic                   slot_live  [TABLE_DEPTH];
   logic [KEY_W-1:0]       slot_key   [TABLE_DEPTH];
   logic [IDENT_W-1:0]     slot_ident [TABLE_DEPTH];
   logic [STAMP_W-1:0]     slot_tag   [TABLE_DEPTH];
   logic [STAMP_W-1:0]     slot_start [TABLE_DEPTH];
   logic [STAMP_W-1:0]     slot_dur   [TABLE_DEPTH];
   logic [31:0]            interval;
   logic [STAMP_W-1:0]     last_check;
   int                     errors   = 0;
   int                     reqs     = 0;
   int                     rsps     = 0;
   int                     expired  = 0;

   task automatic queue_beat(input ktt_status_type st, input logic [KEY_W-1:0] key,
                             input logic [IDENT_W-1:0] ident, input logic [STAMP_W-1:0] tag,
                             input logic [STAMP_W-1:0] el, input logic last);
      timeout_beat_type b;
      b.status  = st;
      b.key     = key;
      b.ident   = ident;
      b.tag     = tag;
      b.elapsed = el;
      b.last    = last;
      expected_beats_q.push_back(b);
   endtask

   task automatic step_timeout_table(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                     input logic [IDENT_W-1:0] ident,
                                     input logic [STAMP_W-1:0] tag, start, dur, now_v);
      int                  hit;
      int                  slot;
      ktt_status_type      st;
      logic [STAMP_W-1:0]  since;
      logic [STAMP_W-1:0]  el;
      hit = -1;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (hit < 0 && slot_live[i] && slot_key[i] == key) hit = i;
      case (op)
         OP_REGISTER: begin
            slot = hit;
            if (slot < 0)
               for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                  if (!slot_live[i]) slot = i;
            if (hit >= 0) st = STAT_OVERWRITTEN;
            else if (slot >= 0) st = STAT_STORED;
            else st = STAT_DROPPED;
            if (slot >= 0) begin
               slot_live[slot]  = 1'b1;
               slot_key[slot]   = key;
               slot_ident[slot] = ident;
               slot_tag[slot]   = tag;
               slot_start[slot] = start;
               slot_dur[slot]   = dur;
            end
            queue_beat(st, key, '0, '0, '0, 1'b1);
         end
         OP_UNREGISTER: begin
            if (hit >= 0) begin
               slot_live[hit] = 1'b0;
               queue_beat(STAT_REMOVED, key, '0, '0, '0, 1'b1);
            end else begin
               queue_beat(STAT_NOT_FOUND, key, '0, '0, '0, 1'b1);
            end
         end
         OP_CHECK: begin
            since = now_v - last_check;
            if (since[STAMP_W-1] || since < {32'd0, interval}) begin
               queue_beat(STAT_SKIPPED, key, '0, '0, '0, 1'b1);
            end else begin
               last_check = now_v;
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  el = now_v - slot_start[i];
                  if (slot_live[i] && $signed(el) >= $signed(slot_dur[i])) begin
                     queue_beat(STAT_EXPIRED, slot_key[i], slot_ident[i], slot_tag[i], el, 1'b0);
                     slot_live[i] = 1'b0;
                  end
               end
               queue_beat(STAT_DONE, key, '0, '0, '0, 1'b1);
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string field, input logic [STAMP_W-1:0] got,
                                  input logic [STAMP_W-1:0] want);
      $display("[%0t] result beat %0d: %s is %h, expected %h", $time, rsps, field, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      timeout_beat_type want;
      if (reset) begin
         interval   = 32'd1000;
         last_check = '0;
         for (int i = 0; i < TABLE_DEPTH; i++) slot_live[i] = 1'b0;
         expected_beats_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsps++;
            if (expected_beats_q.size() == 0) begin
               report_mismatch("unexpected beat, key", 64'(rsp_tdata[31:0]), '0);
            end else begin
               want = expected_beats_q.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 64'(rsp_tuser), 64'(want.status));
               if (rsp_tdata[31:0] !== want.key)
                  report_mismatch("key", 64'(rsp_tdata[31:0]), 64'(want.key));
               if (rsp_tdata[63:32] !== want.ident)
                  report_mismatch("action ident", 64'(rsp_tdata[63:32]), 64'(want.ident));
               if (rsp_tdata[127:64] !== want.tag)
                  report_mismatch("action tag", rsp_tdata[127:64], want.tag);
               if (rsp_tdata[191:128] !== want.elapsed)
                  report_mismatch("elapsed", rsp_tdata[191:128], want.elapsed);
               if (rsp_tlast !== want.last)
                  report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
               if (want.status == STAT_EXPIRED) expired++;
            end
         end
         if (csr_valid && csr_ready) interval = csr_data;
         if (req_tvalid && req_tready) begin
            reqs++;
            step_timeout_table(req_tuser, req_tdata[31:0], req_tdata[63:32],
                               req_tdata[127:64], req_tdata[191:128], req_tdata[255:192],
                               req_tdata[319:256]);
         end
      end
      mismatch_count <= errors;
      pending_beats  <= expected_beats_q.size();
      request_beats  <= reqs;
      result_beats   <= rsps;
      expired_beats  <= expired;
   end

endmodule

@@ verif/keyed_timeout_table_unit_tb.sv @@
// ----------------------------------------------------------------------------
// keyed_timeout_table_unit_tb: testbench for the keyed timeout table
// Drives a directed opener (key and field extremes, overwrite, miss, full
// table, skipped and running checks, wrapped time) and then random phases
// under several check intervals. The sender works in bursts, the receiver
// stalls at random and holds off once for a long stretch. Checking is done
// by the checker instance beside the block.
// ----------------------------------------------------------------------------
module keyed_timeout_table_unit_tb;
   import ktt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
   localparam logic [31:0]     KEY_POOL_BASE  = 32'd16;
   localparam int              KEY_POOL_SIZE  = 24;
   localparam int              PHASE_ITEMS    = 88;
   localparam int              SETTLE_CYCLES  = 24;
   localparam int              HOLD_CYCLES    = 300;
   localparam int              WATCHDOG_LIMIT = 3000;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   // entity_key, action_ident, action_tag, start_stamp, duration, now_stamp
   logic [REQ_DATA_W-1:0]   req_tdata;
   // op
   logic [OP_W-1:0]         req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   // out_key, out_action_ident, out_action_tag, elapsed
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   // status
   logic [STATUS_W-1:0]     rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [31:0]             csr_data;

   int                      mismatch_count;
   int                      pending_beats;
   int                      request_beats;
   int                      result_beats;
   int                      expired_beats;
   int                      burst_left = 1;
   int                      quiet_cycles;
   logic [31:0]             cur_interval = 32'd1000;
   logic [31:0]             interval_plan [5];

   keyed_timeout_table_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   keyed_timeout_table_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_beats  (pending_beats),
      .request_beats  (request_beats),
      .result_beats   (result_beats),
      .expired_beats  (expired_beats)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic offer_item(input logic [OP_W-1:0] op, input logic [31:0] key, ident,
                             input logic [63:0] tag, start, dur, now_v);
      int gap;
      req_tdata  <= {now_v, dur, start, tag, ident, key};
      req_tuser  <= op;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_interval(input logic [31:0] value);
      wait_drained();
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      cur_interval  = value;
   endtask

   // receiver: random-rate stretches, one long hold while requests keep coming
   initial begin
      int seen;
      int span;
      int pct;
      bit held;
      seen = 0;
      held = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         span = $urandom_range(8, 64);
         pct  = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(25, 90);
         for (int c = 0; c < span; c++) begin
            rsp_tready <= ($urandom_range(0, 99) < pct);
            @(posedge clock);
            if (rsp_tvalid && rsp_tready) seen++;
            if (!held && seen >= 150 && req_tvalid) begin
               held = 1'b1;
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      logic [OP_W-1:0]  op;
      logic [31:0]      key;
      logic [31:0]      ident;
      logic [63:0]      tag;
      logic [63:0]      start;
      logic [63:0]      dur;
      logic [63:0]      now_v;
      logic [63:0]      tnow;
      logic [63:0]      step;
      int               r;
      int               sent;
      bit               wide;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed opener
      offer_item(OP_REGISTER, 32'd0, 32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 64'd100,
                 64'hFFFF_FFFF_FFFF_FFFF);
      offer_item(OP_REGISTER, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 64'h8000_0000_0000_0000,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
      offer_item(OP_REGISTER, 32'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd100,
                 64'd0);
      offer_item(OP_UNREGISTER, 32'd5, $urandom, {$urandom, $urandom}, 64'd0, 64'd0, 64'd0);
      offer_item(OP_UNUSED, $urandom, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
      offer_item(OP_CHECK, 32'h1234_5678, 32'd0, 64'd0, 64'd0, 64'd0, 64'd999);
      offer_item(OP_CHECK, 32'hA5A5_5A5A, 32'd0, 64'd0, 64'd0, 64'd0, 64'd1000);
      offer_item(OP_UNREGISTER, 32'hFFFF_FFFF, 32'd0, 64'd0, 64'd0, 64'd0, 64'd0);
      offer_item(OP_CHECK, 32'd7, 32'd0, 64'd0, 64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFB);
      // fill the table and overflow it by one
      for (int i = 0; i <= TABLE_DEPTH; i++) begin
         start = 64'd2000;
         dur   = (i % 2 == 0) ? 64'd50 : 64'h7FFF_FFFF_FFFF_0000;
         if (i == 1) dur = 64'hFFFF_FFFF_FFFF_FF00;
         if (i == 3) begin
            start = 64'h7FFF_FFFF_FFFF_FFF0;
            dur   = 64'd100;
         end
         offer_item(OP_REGISTER, KEY_POOL_BASE + i, $urandom, {$urandom, $urandom}, start, dur,
                    {$urandom, $urandom});
      end
      offer_item(OP_CHECK, 32'd9, 32'd0, 64'd0, 64'd0, 64'd0, 64'd3000);
      tnow = 64'd3000;

      // random phases
      interval_plan[0] = 32'd0;
      interval_plan[1] = 32'hFFFF_FFFF;
      interval_plan[2] = 32'd1;
      interval_plan[3] = $urandom_range(20, 400);
      interval_plan[4] = 32'd1000;
      for (int p = 0; p < 5; p++) begin
         write_interval(interval_plan[p]);
         wide = (cur_interval > 32'd2000);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            r     = $urandom_range(0, 99);
            key   = ($urandom_range(0, 6) == 0) ? $urandom
                                                : KEY_POOL_BASE + $urandom_range(0, KEY_POOL_SIZE - 1);
            ident = $urandom;
            tag   = {$urandom, $urandom};
            start = {$urandom, $urandom};
            dur   = {$urandom, $urandom};
            now_v = {$urandom, $urandom};
            if (r < 45) begin
               op = OP_REGISTER;
               if ($urandom_range(0, 9) != 0) begin
                  start = tnow - $urandom_range(0, 64);
                  if (wide) dur = {$urandom_range(0, 3), $urandom};
                  else dur = 64'($urandom_range(0, 2 * cur_interval + 100));
               end
            end else if (r < 65) begin
               op = OP_UNREGISTER;
            end else if (r < 95) begin
               op = OP_CHECK;
               if ($urandom_range(0, 9) == 0) begin
                  now_v = tnow - $urandom_range(1, 50);
               end else begin
                  if (!wide) step = 64'($urandom_range(0, 2 * cur_interval + 40));
                  else if ($urandom_range(0, 1) == 0) step = {$urandom_range(0, 2), $urandom};
                  else step = 64'($urandom_range(0, 500));
                  tnow  = tnow + step;
                  now_v = tnow;
               end
            end else begin
               op = OP_UNUSED;
            end
            offer_item(op, key, ident, tag, start, dur, now_v);
            if (op != OP_UNUSED) sent++;
         end
      end

      wait_drained();
      $display("run covered %0d request beats under check intervals of 1000, 0, max, 1, %0d",
               request_beats, interval_plan[3]);
      $display("%0d result beats compared, %0d of them expired entries", result_beats,
               expired_beats);
      if (mismatch_count == 0 && pending_beats == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
